>>> rtl/core/sfr_pkg.sv
package sfr_pkg;

  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int POS_W       = 6;
  localparam int CFG_INDEX_W = 2;

  localparam logic [BYTE_W-1:0] FIRST_HEADER_RESET  = 8'd90;
  localparam logic [BYTE_W-1:0] SECOND_HEADER_RESET = 8'd165;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_BYTE     = 2'd0,
    STATUS_EMPTY    = 2'd1,
    STATUS_CSUM_ERR = 2'd2,
    STATUS_LEN_ERR  = 2'd3
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FIRST_HEADER  = 2'd0,
    REG_SECOND_HEADER = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PH_HEAD1,
    PH_HEAD2,
    PH_LEN,
    PH_ID,
    PH_DATA,
    PH_CHECK,
    PH_EMIT_RD,
    PH_EMIT_LD
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_len;
    logic    load_id;
    logic    take_data;
    logic    post;
    status_t post_status;
    logic    emit_start;
    logic    emit_read;
    logic    emit_load;
  } sfr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic head1_match;
    logic head2_match;
    logic len_bad;
    logic len_gt1;
    logic data_done;
    logic sum_ok;
    logic frame_empty;
    logic emit_last;
    logic out_free;
  } sfr_stat_t;

endpackage

>>> rtl/core/sfr_byte_if.sv
interface sfr_byte_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/sfr_result_if.sv
interface sfr_result_if;
  logic                         valid;
  logic                         ready;
  logic [sfr_pkg::STATUS_W-1:0] status;
  logic [sfr_pkg::BYTE_W-1:0]   message_id;
  logic [sfr_pkg::BYTE_W-1:0]   payload_byte;
  logic [sfr_pkg::POS_W-1:0]    byte_position;
  logic                         last_of_frame;

  modport source (output valid, output status, output message_id, output payload_byte,
                  output byte_position, output last_of_frame, input ready);
  modport sink (input valid, input status, input message_id, input payload_byte,
                input byte_position, input last_of_frame, output ready);
endinterface

>>> rtl/core/sfr_cfg_if.sv
interface sfr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [sfr_pkg::CFG_INDEX_W-1:0] index;
  logic [sfr_pkg::BYTE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/sfr_ctrl.sv
module sfr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               rx_valid,
  output logic               rx_ready,
  input  sfr_pkg::sfr_stat_t stat,
  output sfr_pkg::sfr_cmd_t  cmd
);

  sfr_pkg::phase_t phase;
  sfr_pkg::phase_t phase_next;
  logic            rx_take;

  assign rx_take = rx_valid && rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sfr_pkg::PH_HEAD1;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      sfr_pkg::PH_HEAD1: begin
        if (rx_take) phase_next = stat.head1_match ? sfr_pkg::PH_HEAD2 : sfr_pkg::PH_HEAD1;
      end
      sfr_pkg::PH_HEAD2: begin
        // a mismatching byte is not retried as a first header byte
        if (rx_take) phase_next = stat.head2_match ? sfr_pkg::PH_LEN : sfr_pkg::PH_HEAD1;
      end
      sfr_pkg::PH_LEN: begin
        if (rx_take) phase_next = stat.len_bad ? sfr_pkg::PH_HEAD1 : sfr_pkg::PH_ID;
      end
      sfr_pkg::PH_ID: begin
        if (rx_take) phase_next = stat.len_gt1 ? sfr_pkg::PH_DATA : sfr_pkg::PH_CHECK;
      end
      sfr_pkg::PH_DATA: begin
        if (rx_take && stat.data_done) phase_next = sfr_pkg::PH_CHECK;
      end
      sfr_pkg::PH_CHECK: begin
        if (rx_take) begin
          phase_next = (stat.sum_ok && !stat.frame_empty) ? sfr_pkg::PH_EMIT_RD
                                                          : sfr_pkg::PH_HEAD1;
        end
      end
      sfr_pkg::PH_EMIT_RD: begin
        phase_next = sfr_pkg::PH_EMIT_LD;
      end
      sfr_pkg::PH_EMIT_LD: begin
        if (stat.out_free) begin
          phase_next = stat.emit_last ? sfr_pkg::PH_HEAD1 : sfr_pkg::PH_EMIT_RD;
        end
      end
      default: phase_next = sfr_pkg::PH_HEAD1;
    endcase
  end

  always_comb begin
    rx_ready        = 1'b0;
    cmd             = '0;
    cmd.post_status = sfr_pkg::STATUS_BYTE;
    unique case (phase)
      sfr_pkg::PH_HEAD1, sfr_pkg::PH_HEAD2: begin
        rx_ready = 1'b1;
      end
      sfr_pkg::PH_LEN: begin
        // a length error posts a result on this beat, so the slot must be free
        rx_ready        = stat.out_free;
        cmd.load_len    = rx_valid && stat.out_free && !stat.len_bad;
        cmd.post        = rx_valid && stat.out_free && stat.len_bad;
        cmd.post_status = sfr_pkg::STATUS_LEN_ERR;
      end
      sfr_pkg::PH_ID: begin
        rx_ready    = 1'b1;
        cmd.load_id = rx_valid;
      end
      sfr_pkg::PH_DATA: begin
        rx_ready      = 1'b1;
        cmd.take_data = rx_valid;
      end
      sfr_pkg::PH_CHECK: begin
        rx_ready        = stat.out_free;
        cmd.post        = rx_valid && stat.out_free && (!stat.sum_ok || stat.frame_empty);
        cmd.post_status = stat.sum_ok ? sfr_pkg::STATUS_EMPTY : sfr_pkg::STATUS_CSUM_ERR;
        cmd.emit_start  = rx_valid && stat.out_free && stat.sum_ok && !stat.frame_empty;
      end
      sfr_pkg::PH_EMIT_RD: begin
        cmd.emit_read = 1'b1;
      end
      sfr_pkg::PH_EMIT_LD: begin
        cmd.emit_load = stat.out_free;
      end
      default: begin
        rx_ready = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/sfr_datapath.sv
module sfr_datapath #(
  parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [sfr_pkg::BYTE_W-1:0]      rx_byte,
  input  logic                            cfg_valid,
  input  logic [sfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sfr_pkg::BYTE_W-1:0]      cfg_data,
  input  sfr_pkg::sfr_cmd_t               cmd,
  output sfr_pkg::sfr_stat_t              stat,
  output logic                            res_valid,
  input  logic                            res_ready,
  output logic [sfr_pkg::STATUS_W-1:0]    res_status,
  output logic [sfr_pkg::BYTE_W-1:0]      res_id,
  output logic [sfr_pkg::BYTE_W-1:0]      res_payload,
  output logic [sfr_pkg::POS_W-1:0]       res_pos,
  output logic                            res_last
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int TW = $clog2(MAX_PAYLOAD + 1);
  localparam logic [8:0] LEN_LIMIT = 9'(MAX_PAYLOAD + 1);

  logic [sfr_pkg::BYTE_W-1:0] first_header;
  logic [sfr_pkg::BYTE_W-1:0] second_header;
  logic [sfr_pkg::BYTE_W-1:0] frame_length;
  logic [sfr_pkg::BYTE_W-1:0] frame_id;
  logic [sfr_pkg::BYTE_W-1:0] running_sum;
  logic [TW-1:0]              bytes_taken;
  logic [AW-1:0]              emit_idx;
  logic [sfr_pkg::BYTE_W-1:0] rd_data;
  logic [sfr_pkg::BYTE_W-1:0] payload_store [MAX_PAYLOAD];

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header  <= sfr_pkg::FIRST_HEADER_RESET;
      second_header <= sfr_pkg::SECOND_HEADER_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == sfr_pkg::REG_FIRST_HEADER) first_header <= cfg_data;
      if (cfg_index == sfr_pkg::REG_SECOND_HEADER) second_header <= cfg_data;
    end
  end

  always_comb begin
    stat.head1_match = (rx_byte == first_header);
    stat.head2_match = (rx_byte == second_header);
    stat.len_bad     = (rx_byte == 8'd0) || ({1'b0, rx_byte} > LEN_LIMIT);
    stat.len_gt1     = (frame_length > 8'd1);
    // last payload beat when the count after this one reaches length minus one
    stat.data_done   = ((9'(bytes_taken) + 9'd2) >= {1'b0, frame_length});
    stat.sum_ok      = (rx_byte == running_sum);
    stat.frame_empty = (frame_length == 8'd1);
    stat.emit_last   = ((9'(emit_idx) + 9'd2) == {1'b0, frame_length});
    stat.out_free    = !res_valid || res_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_len) begin
      frame_length <= rx_byte;
      running_sum  <= first_header + second_header + rx_byte;
    end
    if (cmd.load_id) begin
      frame_id    <= rx_byte;
      running_sum <= running_sum + rx_byte;
      bytes_taken <= '0;
    end
    if (cmd.take_data) begin
      running_sum <= running_sum + rx_byte;
      bytes_taken <= bytes_taken + 1'b1;
    end
    if (cmd.emit_start) begin
      emit_idx <= '0;
    end else if (cmd.emit_load) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      payload_store[bytes_taken[AW-1:0]] <= rx_byte;
    end
    if (cmd.emit_read) begin
      rd_data <= payload_store[emit_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.post || cmd.emit_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      res_status  <= cmd.post_status;
      // length errors come before the id byte
      res_id      <= (cmd.post_status == sfr_pkg::STATUS_LEN_ERR) ? 8'd0 : frame_id;
      res_payload <= 8'd0;
      res_pos     <= '0;
      res_last    <= 1'b1;
    end else if (cmd.emit_load) begin
      res_status  <= sfr_pkg::STATUS_BYTE;
      res_id      <= frame_id;
      res_payload <= rd_data;
      res_pos     <= sfr_pkg::POS_W'(emit_idx);
      res_last    <= stat.emit_last;
    end
  end

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (cmd.post || cmd.emit_load) |=> res_valid)
    else $error("result not registered after post");

  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (cmd.post || cmd.emit_load) |-> (!res_valid || res_ready))
    else $error("result slot overwritten while still pending");

  a_store_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.take_data |-> (32'(bytes_taken) < MAX_PAYLOAD))
    else $error("payload write beyond store depth");

endmodule

>>> rtl/core/serial_frame_receiver_core.sv
// Serial frame receiver.
// rx carries one received byte per beat. The block hunts for the two header
// bytes, takes a length byte (payload count plus one), an id byte, the
// payload and an 8-bit additive checksum over everything before it.
// res carries results: one beat per payload byte of a good frame (last one
// marked), or one beat for an empty frame, a checksum error or a length error.
// cfg writes the header bytes: index 0 first header, index 1 second header.
// cfg is always ready; write it only while the block is idle.
// Throughput: one rx byte per cycle while parsing. An error or empty-frame
// result is registered the cycle after its byte; the length and checksum
// beats wait for the result register to be free. After a good checksum, rx
// is held off while the payload is read back from the store: each payload
// beat takes a registered store read, then a result load that waits for a
// free result register. A stalled res holds its beat; while parsing, rx
// stalls on it only at a length or checksum beat.
// Reset (rst, synchronous) returns to header hunt, restores the default
// header bytes and empties the result register; the store is not cleared.
module serial_frame_receiver_core #(
  parameter int MAX_PAYLOAD = sfr_pkg::MAX_PAYLOAD_DEF
) (
  input logic          clk,
  input logic          rst,
  sfr_byte_if.sink     rx,
  sfr_result_if.source res,
  sfr_cfg_if.sink      cfg
);

  sfr_pkg::sfr_cmd_t  cmd;
  sfr_pkg::sfr_stat_t stat;

  assign cfg.ready = 1'b1;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (rx.rx_byte),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .cmd         (cmd),
    .stat        (stat),
    .res_valid   (res.valid),
    .res_ready   (res.ready),
    .res_status  (res.status),
    .res_id      (res.message_id),
    .res_payload (res.payload_byte),
    .res_pos     (res.byte_position),
    .res_last    (res.last_of_frame)
  );

endmodule
